// ===== rtl/pxe_pkg.sv =====
package pxe_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int ITER_W      = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ITER_W-1:0] iter_t;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BADCHAR = 3'd1;
	localparam logic [2:0] ST_UNDER   = 3'd2;
	localparam logic [2:0] ST_OVER    = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;
	localparam logic [2:0] ST_INVALID = 3'd5;
	localparam logic [2:0] ST_ZERONEG = 3'd6;

	// Characters of the expression alphabet.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_POW
	} alu_op_t;

	typedef enum logic [1:0] {
		AL_IDLE,
		AL_DIV,
		AL_POW,
		AL_FIN
	} alu_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_READ,
		SQ_WAIT,
		SQ_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [7:0] token;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} out_item_t;

	typedef struct packed {
		logic  push;
		logic  read;
		logic  pop;
		logic  clear;
		word_t data;
	} stk_cmd_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

endpackage

// ===== rtl/pxe_stack.sv =====
// Operand stack. The top entry lives in a register; the entries below it
// live in a memory with one write and one registered read port.
module pxe_stack (
	input  logic             clk,
	input  logic             arst_n,
	input  pxe_pkg::stk_cmd_t cmd,
	output pxe_pkg::word_t   tos,
	output pxe_pkg::cnt_t    count,
	output pxe_pkg::word_t   rd_data
);

	pxe_pkg::word_t mem [pxe_pkg::STACK_DEPTH];
	pxe_pkg::word_t tos_q;
	pxe_pkg::word_t rd_q;
	pxe_pkg::cnt_t  count_q;
	pxe_pkg::cnt_t  cnt_m1;
	pxe_pkg::cnt_t  cnt_m2;
	pxe_pkg::addr_t wr_addr;
	pxe_pkg::addr_t rd_addr;

	assign cnt_m1  = count_q - pxe_pkg::cnt_t'(1);
	assign cnt_m2  = count_q - pxe_pkg::cnt_t'(2);
	assign wr_addr = cnt_m1[pxe_pkg::ADDR_W-1:0];
	assign rd_addr = cnt_m2[pxe_pkg::ADDR_W-1:0];

	// A push spills the old top into the memory; the read fetches the
	// entry just below the top.
	always_ff @(posedge clk) begin
		if (cmd.push && count_q != '0) begin
			mem[wr_addr] <= tos_q;
		end
		if (cmd.read) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.push || cmd.pop) begin
			tos_q <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + pxe_pkg::cnt_t'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	assign tos     = tos_q;
	assign count   = count_q;
	assign rd_data = rd_q;

endmodule

// ===== rtl/pxe_alu.sv =====
// Shared arithmetic unit. Add, subtract and multiply finish in one step,
// division runs one quotient bit per cycle, power with a nonnegative exponent
// runs one exponent bit per cycle by square-and-multiply.
module pxe_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  pxe_pkg::alu_req_t req,
	input  pxe_pkg::word_t    lhs,
	input  pxe_pkg::word_t    rhs,
	output pxe_pkg::alu_rsp_t rsp,
	output pxe_pkg::word_t    result
);

	pxe_pkg::alu_state_t state_q, state_d;
	pxe_pkg::word_t      x_q;
	pxe_pkg::word_t      y_q;
	pxe_pkg::word_t      z_q;
	pxe_pkg::iter_t      cnt_q;
	logic                neg_q;

	logic [pxe_pkg::DATA_W:0] shifted;
	logic [pxe_pkg::DATA_W:0] diff;
	logic                     ge;
	pxe_pkg::word_t           lhs_mag;
	pxe_pkg::word_t           rhs_mag;
	pxe_pkg::word_t           neg_pow;

	assign lhs_mag = lhs[pxe_pkg::DATA_W-1] ? -lhs : lhs;
	assign rhs_mag = rhs[pxe_pkg::DATA_W-1] ? -rhs : rhs;

	// Result of a negative exponent: only a base of plus or minus one
	// survives; a zero base is trapped before the unit is started.
	always_comb begin
		if (lhs == pxe_pkg::word_t'(1)) begin
			neg_pow = pxe_pkg::word_t'(1);
		end else if (lhs == '1) begin
			neg_pow = rhs[0] ? '1 : pxe_pkg::word_t'(1);
		end else begin
			neg_pow = '0;
		end
	end

	assign shifted = {x_q, y_q[pxe_pkg::DATA_W-1]};
	assign diff    = shifted - {1'b0, z_q};
	assign ge      = shifted >= {1'b0, z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pxe_pkg::AL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rsp     = '0;
		unique case (state_q)
			pxe_pkg::AL_IDLE: begin
				if (req.start) begin
					if (req.op == pxe_pkg::ALU_DIV) begin
						state_d = pxe_pkg::AL_DIV;
					end else if (req.op == pxe_pkg::ALU_POW && !rhs[pxe_pkg::DATA_W-1]) begin
						state_d = pxe_pkg::AL_POW;
					end else begin
						state_d = pxe_pkg::AL_FIN;
					end
				end
			end
			pxe_pkg::AL_DIV: begin
				if (cnt_q == '1) begin
					state_d = pxe_pkg::AL_FIN;
				end
			end
			pxe_pkg::AL_POW: begin
				if (z_q == '0) begin
					state_d = pxe_pkg::AL_FIN;
				end
			end
			pxe_pkg::AL_FIN: begin
				rsp.done = 1'b1;
				state_d  = pxe_pkg::AL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pxe_pkg::AL_IDLE: begin
				// Only a divide negates its result, when the operand signs differ.
				neg_q <= req.start && req.op == pxe_pkg::ALU_DIV &&
					(lhs[pxe_pkg::DATA_W-1] ^ rhs[pxe_pkg::DATA_W-1]);
				cnt_q <= '0;
				if (req.start) begin
					case (req.op)
						pxe_pkg::ALU_ADD: x_q <= lhs + rhs;
						pxe_pkg::ALU_SUB: x_q <= lhs - rhs;
						pxe_pkg::ALU_MUL: x_q <= lhs * rhs;
						pxe_pkg::ALU_DIV: begin
							x_q <= '0;
							y_q <= lhs_mag;
							z_q <= rhs_mag;
						end
						pxe_pkg::ALU_POW: begin
							if (rhs[pxe_pkg::DATA_W-1]) begin
								x_q <= neg_pow;
							end else begin
								x_q <= pxe_pkg::word_t'(1);
								y_q <= lhs;
								z_q <= rhs;
							end
						end
						default: x_q <= '0;
					endcase
				end
			end
			pxe_pkg::AL_DIV: begin
				// Restoring division, one quotient bit per cycle. On the last
				// bit the quotient moves into x_q for the final sign fix.
				cnt_q <= cnt_q + pxe_pkg::iter_t'(1);
				y_q   <= {y_q[pxe_pkg::DATA_W-2:0], ge};
				if (cnt_q == '1) begin
					x_q <= {y_q[pxe_pkg::DATA_W-2:0], ge};
				end else if (ge) begin
					x_q <= diff[pxe_pkg::DATA_W-1:0];
				end else begin
					x_q <= shifted[pxe_pkg::DATA_W-1:0];
				end
			end
			pxe_pkg::AL_POW: begin
				if (z_q != '0) begin
					if (z_q[0]) begin
						x_q <= x_q * y_q;
					end
					y_q <= y_q * y_q;
					z_q <= z_q >> 1;
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign result = neg_q ? -x_q : x_q;

endmodule

// ===== rtl/prefix_expression_stack_evaluator.sv =====
// Prefix expression evaluator.
//
// Characters of a prefix expression arrive on the input channel (in_valid,
// in_ready, in_data) from the rightmost to the leftmost, one per transfer.
// Digits push their value onto an operand stack; the operators + - * / ^
// pop two operands and push the wrapped 32-bit result. The transfer marked
// last ends the expression and yields exactly one result transfer on the
// output channel (out_valid, out_ready, out_data) with the value and a
// status code; the stack and the status are then cleared for the next one.
//
// A digit or an ignored character that is not the last stays in the idle state.
// An add, subtract or multiply goes through the stack read and the
// one-step pass through the shared unit. A divide runs one quotient bit
// per cycle. A power runs one exponent bit per cycle, ending at the highest
// set bit. The last character then passes through the emit state to load
// the output register.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register while out_ready is low; the block keeps taking characters
// until it holds off the next result, and takes none until the register frees.
// Reset empties the stack, clears the status and drops any pending result.
module prefix_expression_stack_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pxe_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pxe_pkg::out_item_t out_data
);

	pxe_pkg::seq_state_t state_q, state_d;
	pxe_pkg::stk_cmd_t   stk_cmd;
	pxe_pkg::alu_req_t   alu_req;
	pxe_pkg::alu_rsp_t   alu_rsp;
	pxe_pkg::word_t      tos;
	pxe_pkg::word_t      rd_data;
	pxe_pkg::word_t      alu_result;
	pxe_pkg::cnt_t       count;

	logic [2:0]          err_q, err_d;
	pxe_pkg::alu_op_t    op_q, op_dec;
	logic                last_q;
	logic                is_op;
	logic                is_digit;
	logic [7:0]          digit;
	logic                accept;
	logic                out_load;
	logic                out_valid_q;
	pxe_pkg::out_item_t  out_q;
	pxe_pkg::out_item_t  emit;
	pxe_pkg::seq_state_t after_op;

	pxe_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (stk_cmd),
		.tos     (tos),
		.count   (count),
		.rd_data (rd_data)
	);

	pxe_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (tos),
		.rhs    (rd_data),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	assign in_ready = (state_q == pxe_pkg::SQ_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_digit = (in_data.token >= pxe_pkg::CH_ZERO) && (in_data.token <= pxe_pkg::CH_NINE);
	assign digit    = in_data.token - pxe_pkg::CH_ZERO;
	assign after_op = last_q ? pxe_pkg::SQ_EMIT : pxe_pkg::SQ_IDLE;

	// Operator decode.
	always_comb begin
		is_op  = 1'b1;
		op_dec = pxe_pkg::ALU_ADD;
		unique case (in_data.token)
			pxe_pkg::CH_PLUS:  op_dec = pxe_pkg::ALU_ADD;
			pxe_pkg::CH_MINUS: op_dec = pxe_pkg::ALU_SUB;
			pxe_pkg::CH_STAR:  op_dec = pxe_pkg::ALU_MUL;
			pxe_pkg::CH_SLASH: op_dec = pxe_pkg::ALU_DIV;
			pxe_pkg::CH_CARET: op_dec = pxe_pkg::ALU_POW;
			default:           is_op  = 1'b0;
		endcase
	end

	// Result: the first error, else the lone value left, else invalid.
	always_comb begin
		if (err_q != pxe_pkg::ST_OK) begin
			emit.status = err_q;
		end else if (count == pxe_pkg::cnt_t'(1)) begin
			emit.status = pxe_pkg::ST_OK;
		end else begin
			emit.status = pxe_pkg::ST_INVALID;
		end
		emit.value = (emit.status == pxe_pkg::ST_OK) ? $signed(tos) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pxe_pkg::SQ_IDLE;
			err_q   <= pxe_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_dec;
			last_q <= in_data.last;
		end
	end

	// Sequencer. An error is sticky: once set, characters are dropped
	// until the last one reports it.
	always_comb begin
		state_d       = state_q;
		err_d         = err_q;
		stk_cmd       = '0;
		stk_cmd.data  = pxe_pkg::word_t'(digit);
		alu_req       = '0;
		alu_req.op    = op_q;
		out_load      = 1'b0;
		unique case (state_q)
			pxe_pkg::SQ_IDLE: begin
				if (in_valid) begin
					state_d = in_data.last ? pxe_pkg::SQ_EMIT : pxe_pkg::SQ_IDLE;
					if (err_q == pxe_pkg::ST_OK) begin
						if (is_digit) begin
							if (count >= pxe_pkg::cnt_t'(pxe_pkg::STACK_DEPTH)) begin
								err_d = pxe_pkg::ST_OVER;
							end else begin
								stk_cmd.push = 1'b1;
							end
						end else if (is_op) begin
							if (count < pxe_pkg::cnt_t'(2)) begin
								err_d = pxe_pkg::ST_UNDER;
							end else begin
								stk_cmd.read = 1'b1;
								state_d      = pxe_pkg::SQ_READ;
							end
						end else begin
							err_d = pxe_pkg::ST_BADCHAR;
						end
					end
				end
			end
			pxe_pkg::SQ_READ: begin
				// The right operand is now out of the memory; trap the two
				// operand errors before the unit starts.
				if (op_q == pxe_pkg::ALU_DIV && rd_data == '0) begin
					err_d   = pxe_pkg::ST_DIVZERO;
					state_d = after_op;
				end else if (op_q == pxe_pkg::ALU_POW && rd_data[pxe_pkg::DATA_W-1] && tos == '0) begin
					err_d   = pxe_pkg::ST_ZERONEG;
					state_d = after_op;
				end else begin
					alu_req.start = 1'b1;
					state_d       = pxe_pkg::SQ_WAIT;
				end
			end
			pxe_pkg::SQ_WAIT: begin
				if (alu_rsp.done) begin
					stk_cmd.pop  = 1'b1;
					stk_cmd.data = alu_result;
					state_d      = after_op;
				end
			end
			pxe_pkg::SQ_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load      = 1'b1;
					stk_cmd.clear = 1'b1;
					err_d         = pxe_pkg::ST_OK;
					state_d       = pxe_pkg::SQ_IDLE;
				end
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= emit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/pxe_chk.sv =====
module pxe_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input pxe_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input pxe_pkg::out_item_t out_data
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A failed expression reports a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != pxe_pkg::ST_OK |-> out_data.value == '0)
		else $error("nonzero value with error status");

	// A character that does not end the expression makes no result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last && !out_valid |=> !out_valid)
		else $error("result without a last character");

	// The block is busy producing the result after the last character.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last |=> !in_ready)
		else $error("ready right after last character");

endmodule

bind prefix_expression_stack_evaluator pxe_chk u_pxe_chk (.*);

// ===== tb/sv/testbench.sv =====
module testbench;

	// Clock and run control.
	localparam int CLK_HALF     = 6;
	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 100;

	// Stimulus sizing. The target counts every character that is transferred,
	// including those swallowed behind a sticky error.
	localparam int ITEM_TARGET = 1050;
	localparam int DIR_ROWS    = 25;

	// The long output stall starts once this many characters have gone in.
	// It lasts long enough for a second result to back up and block the input.
	localparam int HOLD_AFTER  = 200;
	localparam int HOLD_CYCLES = 600;

	localparam int REPORT_MAX = 10;

	localparam logic [4:0][7:0] OP_CHARS = {pxe_pkg::CH_CARET, pxe_pkg::CH_SLASH,
		pxe_pkg::CH_STAR, pxe_pkg::CH_MINUS, pxe_pkg::CH_PLUS};

	// One row of the directed table. When "typed" is set, the result written in the row
	// is the one expected. Otherwise the expression evaluator below supplies it.
	typedef struct packed {
		logic [7:0]         token;
		logic               last;
		logic               typed;
		logic signed [31:0] value;
		logic [2:0]         status;
	} stim_row_t;

	// The directed expressions, in arrival order (rightmost character first).
	stim_row_t directed_rows [DIR_ROWS] = '{
		// A lone digit is a complete expression.
		'{pxe_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1, 32'sd5, pxe_pkg::ST_OK},
		// An operator with an empty stack underflows.
		'{pxe_pkg::CH_PLUS,        1'b1, 1'b1, 32'sd0, pxe_pkg::ST_UNDER},
		// A NUL character is rejected. The 0xFF after it is ignored, so the error sticks.
		'{8'h00,                   1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{8'hFF,                   1'b1, 1'b1, 32'sd0, pxe_pkg::ST_BADCHAR},
		// "/ 5 0" divides by zero.
		'{pxe_pkg::CH_ZERO,        1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_SLASH,       1'b1, 1'b1, 32'sd0, pxe_pkg::ST_DIVZERO},
		// "^ 0 - 0 1" raises zero to the power of minus one.
		'{pxe_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO,        1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_MINUS,       1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO,        1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_CARET,       1'b1, 1'b1, 32'sd0, pxe_pkg::ST_ZERONEG},
		// "9 9" leaves two values on the stack.
		'{pxe_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO + 8'd9, 1'b1, 1'b1, 32'sd0, pxe_pkg::ST_INVALID},
		// "/ ^ 2 + * 3 9 4 - 0 1" builds 2^31, which wraps to the most negative word.
		// It then divides that by minus one, and the quotient wraps again.
		// Every operator appears in this one.
		'{pxe_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO,        1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_MINUS,       1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_STAR,        1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_PLUS,        1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_CARET,       1'b0, 1'b0, 32'sd0, pxe_pkg::ST_OK},
		'{pxe_pkg::CH_SLASH,       1'b1, 1'b0, 32'sd0, pxe_pkg::ST_OK}
	};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	pxe_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	pxe_pkg::out_item_t out_data;

	prefix_expression_stack_evaluator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #CLK_HALF clk = ~clk;

	// Our own copy of the evaluator state, advanced once per accepted character.
	pxe_pkg::word_t opnd_stack [pxe_pkg::STACK_DEPTH];
	int unsigned    opnd_count    = 0;
	logic [2:0]     sticky_status = pxe_pkg::ST_OK;

	pxe_pkg::out_item_t expected_results [$];
	logic [7:0]         expr_chars [$];

	int unsigned send_idle_pct  = 24;
	int unsigned recv_stall_pct = 54;
	int unsigned n_accepted     = 0;
	int unsigned n_live         = 0;
	int unsigned n_checked      = 0;
	int unsigned n_fail         = 0;
	int unsigned status_seen [8] = '{default: 0};
	int unsigned hold_left      = 0;
	logic        hold_done      = 1'b0;

	// Apply one character to the stack.
	// Returns 1 when the character ends an expression; the result is then in res.
	// Once an error is latched, every character is ignored until the last one, which
	// reports the first error with a zero value.
	function automatic logic evaluate_char(input pxe_pkg::in_item_t ch,
			output pxe_pkg::out_item_t res);
		pxe_pkg::word_t lhs, rhs, r, base, ex, mag_l, mag_r;
		res = '0;
		if (sticky_status == pxe_pkg::ST_OK) begin
			if (ch.token >= pxe_pkg::CH_ZERO && ch.token <= pxe_pkg::CH_NINE) begin
				if (opnd_count >= pxe_pkg::STACK_DEPTH) begin
					sticky_status = pxe_pkg::ST_OVER;
				end else begin
					opnd_stack[pxe_pkg::addr_t'(opnd_count)] =
						pxe_pkg::word_t'(ch.token) - pxe_pkg::word_t'(pxe_pkg::CH_ZERO);
					opnd_count++;
				end
			end else if (ch.token != pxe_pkg::CH_PLUS && ch.token != pxe_pkg::CH_MINUS &&
					ch.token != pxe_pkg::CH_STAR && ch.token != pxe_pkg::CH_SLASH &&
					ch.token != pxe_pkg::CH_CARET) begin
				sticky_status = pxe_pkg::ST_BADCHAR;
			end else if (opnd_count < 2) begin
				sticky_status = pxe_pkg::ST_UNDER;
			end else begin
				// The top of the stack is the left operand.
				lhs = opnd_stack[pxe_pkg::addr_t'(opnd_count - 1)];
				rhs = opnd_stack[pxe_pkg::addr_t'(opnd_count - 2)];
				r   = '0;
				case (ch.token)
					pxe_pkg::CH_PLUS: begin
						r = lhs + rhs;
					end
					pxe_pkg::CH_MINUS: begin
						r = lhs - rhs;
					end
					pxe_pkg::CH_STAR: begin
						r = lhs * rhs;
					end
					pxe_pkg::CH_SLASH: begin
						if (rhs == '0) begin
							sticky_status = pxe_pkg::ST_DIVZERO;
						end else begin
							// Divide the magnitudes, then negate if the signs differ.
							// This truncates toward zero and wraps the most negative
							// word divided by minus one.
							mag_l = lhs[31] ? pxe_pkg::word_t'(0) - lhs : lhs;
							mag_r = rhs[31] ? pxe_pkg::word_t'(0) - rhs : rhs;
							r     = mag_l / mag_r;
							if (lhs[31] != rhs[31])
								r = pxe_pkg::word_t'(0) - r;
						end
					end
					default: begin
						if (rhs[31]) begin
							// A negative exponent leaves only 1 and -1 as bases with a
							// nonzero result. A zero base is an error.
							if (lhs == '0)
								sticky_status = pxe_pkg::ST_ZERONEG;
							else if (lhs == pxe_pkg::word_t'(1))
								r = pxe_pkg::word_t'(1);
							else if (lhs == '1)
								r = rhs[0] ? '1 : pxe_pkg::word_t'(1);
							else
								r = '0;
						end else begin
							r    = pxe_pkg::word_t'(1);
							base = lhs;
							ex   = rhs;
							while (ex != '0) begin
								if (ex[0])
									r = r * base;
								base = base * base;
								ex   = ex >> 1;
							end
						end
					end
				endcase
				// A failed divide or power leaves the stack as it was.
				if (sticky_status == pxe_pkg::ST_OK) begin
					opnd_count--;
					opnd_stack[pxe_pkg::addr_t'(opnd_count - 1)] = r;
				end
			end
		end
		if (!ch.last)
			return 1'b0;
		res.status = sticky_status;
		if (sticky_status == pxe_pkg::ST_OK) begin
			if (opnd_count == 1)
				res.value = opnd_stack[0];
			else
				res.status = pxe_pkg::ST_INVALID;
		end
		opnd_count    = 0;
		sticky_status = pxe_pkg::ST_OK;
		return 1'b1;
	endfunction

	task automatic flag_failure(input string what);
		n_fail++;
		if (n_fail <= REPORT_MAX)
			$display("MISMATCH: %s", what);
	endtask

	// Offer one character and wait for its transfer.
	// A random gap may come first, and valid drops only during such a gap. Back-to-back
	// characters keep valid high without a glitch. Once the transfer happens, the
	// character is applied to our own stack copy. Any result it ends is queued.
	task automatic feed_char(input logic [7:0] tok, input logic lst,
			input logic use_typed, input pxe_pkg::out_item_t typed_res);
		pxe_pkg::in_item_t  item;
		pxe_pkg::out_item_t predicted;
		logic               was_stuck;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		item.token = tok;
		item.last  = lst;
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		was_stuck = (sticky_status != pxe_pkg::ST_OK);
		if (evaluate_char(item, predicted))
			expected_results.push_back(use_typed ? typed_res : predicted);
		n_accepted++;
		if (!(was_stuck && !lst))
			n_live++;
	endtask

	task automatic feed_expression();
		foreach (expr_chars[i])
			feed_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, '0);
	endtask

	// Build a well-formed expression with n_ops operators, in arrival order.
	// The digits and operators go in the same order a postfix stack machine would see
	// them. With pack_first set, every digit comes before any operator, so the stack
	// gets as deep as the expression allows.
	function automatic void build_expression(int unsigned n_ops, logic pack_first);
		int unsigned digits_left, ops_left, depth;
		digits_left = n_ops + 1;
		ops_left    = n_ops;
		depth       = 0;
		expr_chars.delete();
		while (digits_left + ops_left != 0) begin
			if (digits_left != 0 && (depth < 2 || pack_first || $urandom_range(0, 2) != 0)) begin
				expr_chars.push_back(pxe_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				digits_left--;
				depth++;
			end else begin
				expr_chars.push_back(OP_CHARS[3'($urandom_range(0, 4))]);
				ops_left--;
				depth--;
			end
		end
	endfunction

	// The random part has three thirds with different idle patterns.
	// Each round sends one expression. Most rounds are well formed with random digits
	// and operators, and a few fill the stack to its full depth. The rest overflow the
	// stack, are corrupted versions of good expressions, or are random bytes.
	task automatic run_random();
		int unsigned rnd_start, phase, pick, idx;
		rnd_start = n_accepted;
		while (n_accepted < ITEM_TARGET) begin
			phase = (n_accepted - rnd_start) * 3 / (ITEM_TARGET - rnd_start);
			case (phase)
				0: begin
					send_idle_pct  = 24;
					recv_stall_pct = 54;
				end
				1: begin
					send_idle_pct  = 54;
					recv_stall_pct = 24;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 66) begin
				build_expression($urandom_range(0, 10), 1'b0);
			end else if (pick < 70) begin
				build_expression(pxe_pkg::STACK_DEPTH - 1, 1'b1);
			end else if (pick < 75) begin
				// Push one to three digits more than the stack can hold.
				expr_chars.delete();
				repeat (pxe_pkg::STACK_DEPTH + $urandom_range(1, 3))
					expr_chars.push_back(pxe_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 1))
					expr_chars.push_back(OP_CHARS[3'($urandom_range(0, 4))]);
			end else if (pick < 90) begin
				build_expression($urandom_range(1, 8), 1'b0);
				idx = $urandom_range(0, expr_chars.size() - 1);
				case ($urandom_range(0, 3))
					0: begin
						expr_chars[idx] = 8'($urandom_range(0, 255));
					end
					1: begin
						expr_chars.delete(idx);
					end
					2: begin
						expr_chars.push_back(pxe_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
					end
					default: begin
						// End the expression at idx, before its leftmost operator unless idx is already the last.
						while (expr_chars.size() > idx + 1)
							void'(expr_chars.pop_back());
					end
				endcase
			end else begin
				expr_chars.delete();
				repeat ($urandom_range(1, 6))
					expr_chars.push_back(8'($urandom_range(0, 255)));
			end
			feed_expression();
		end
	endtask

	// Receiver side. This process stalls out_ready at random.
	// Once, after enough characters have gone in, it holds out_ready low for a long
	// stretch. It counts that stretch in cycles itself. The sender keeps offering
	// characters during the stall, so a second result backs up behind the first and
	// the block must stop taking input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Result checker. Each result transfer is compared with the oldest queued
	// expectation.
	always @(posedge clk) begin
		pxe_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_failure($sformatf("result value=%0d status=%0d arrived with none expected",
					out_data.value, out_data.status));
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (out_data.value !== want.value || out_data.status !== want.status)
					flag_failure($sformatf(
						"result %0d: expected value=%0d status=%0d, got value=%0d status=%0d",
						n_checked, want.value, want.status, out_data.value, out_data.status));
				else
					status_seen[want.status]++;
			end
		end
	end

	initial begin
		pxe_pkg::out_item_t typed_res;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			typed_res.value  = directed_rows[i].value;
			typed_res.status = directed_rows[i].status;
			feed_char(directed_rows[i].token, directed_rows[i].last, directed_rows[i].typed,
				typed_res);
		end

		run_random();
		in_valid <= 1'b0;

		// Let the last results come out, then allow some slack for anything extra.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters (%0d acted on), checked %0d expression results.",
			n_accepted, n_live, n_checked);
		$display("Status mix: ok %0d, %s%0d, %s%0d, %s%0d, %s%0d, %s%0d, %s%0d",
			status_seen[pxe_pkg::ST_OK],
			"bad char ", status_seen[pxe_pkg::ST_BADCHAR],
			"underflow ", status_seen[pxe_pkg::ST_UNDER],
			"overflow ", status_seen[pxe_pkg::ST_OVER],
			"div by zero ", status_seen[pxe_pkg::ST_DIVZERO],
			"invalid ", status_seen[pxe_pkg::ST_INVALID],
			"zero to negative power ", status_seen[pxe_pkg::ST_ZERONEG]);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog. This limit is far beyond the slowest correct run.
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("Timeout with %0d results still expected.", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
